// ===== rtl/form_urlencoded_decoder_macros.svh =====
// Assertion macros used by the form-urlencoded decoder checker.
// Depends on nothing; include it by its bare file name.
`ifndef FORM_URLENCODED_DECODER_MACROS_SVH
`define FORM_URLENCODED_DECODER_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define FUD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FUD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fud_pkg.sv =====
// Shared constants, types and the hex digit rule of the form-urlencoded decoder.
// Depends on nothing; every fud_* module imports it.
package fud_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CASE_MASK  = 8'hDF;
	localparam logic [7:0] HEX_TEN    = 8'd10;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned USER_W = 4;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_HIGH = 2'd1,
		ESC_LOW  = 2'd2
	} esc_phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_present;
		logic              in_value_part;
		logic              name_done;
		logic              pair_done;
		logic              bad_escape;
	} dec_res_t;

	// Loose hex rule: letters fold case, everything else counts from '0'; wraps mod 256.
	function automatic logic [7:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		if (c >= CH_UPPER_A) begin
			d = ((c & CASE_MASK) - CH_UPPER_A) + HEX_TEN;
		end else begin
			d = c - CH_ZERO;
		end
		return d;
	endfunction

endpackage

// ===== rtl/form_urlencoded_decoder.sv =====
// Top level of the form-urlencoded decoder: input register, decode step, output register.
// Depends on fud_pkg, fud_in_stage, fud_decode and fud_out_stage.
//
// Usage:
//   The slave stream carries the raw body, one byte per word: tdata is the byte and
//   tlast marks the final byte of the body. The master stream carries decoded
//   results: tdata is the decoded byte (zero when none), tlast closes a pair (raw '&'
//   or body end), and tuser flags what the word holds.
//   Words that produce nothing (a '%' or the first escape digit) are dropped
//   inside the block and never appear on the master side.
//   A result passes from the input register through the decode step into the output
//   register. Throughput: one word per cycle unless the receiver stalls, set by
//   the single decode step between the input register and the output register; pair
//   state (escape phase, high nibble, name/value flag) updates in that same cycle.
//   Reset (arst_n low) empties both registers and returns the pair state to the
//   start of a name with no escape pending.
//   When the receiver stalls, the output register holds its word unchanged; the
//   input register still drains words that produce no result, and holds a word with
//   a result until the output register frees, which then drops s_axis_tready.
module form_urlencoded_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [fud_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] in_byte
	input  logic                       s_axis_tlast,  // body_last
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [fud_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] out_byte
	output logic                       m_axis_tlast,  // pair_done
	output logic [fud_pkg::USER_W-1:0] m_axis_tuser   // [0] byte_present,
	                                                  // [1] in_value_part,
	                                                  // [2] name_done, [3] bad_escape
);
	import fud_pkg::*;

	logic              s1_valid;
	logic [BYTE_W-1:0] s1_byte;
	logic              s1_last;
	logic              has_result;
	dec_res_t          res;
	logic              out_free;
	logic              advance;
	logic              load;

	// advance the held word when it has no result, or when the output register
	// can take its result this cycle
	assign advance = s1_valid && (!has_result || out_free);
	assign load    = has_result && out_free;

	fud_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.advance  (advance),
		.s1_valid (s1_valid),
		.s1_byte  (s1_byte),
		.s1_last  (s1_last)
	);

	fud_decode u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s1_valid),
		.item_byte  (s1_byte),
		.item_last  (s1_last),
		.advance    (advance),
		.has_result (has_result),
		.res        (res)
	);

	fud_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.out_free  (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_user  (m_axis_tuser)
	);

endmodule

// ===== rtl/fud_in_stage.sv =====
// Input register of the form-urlencoded decoder: holds one raw word and its last flag.
// Depends on fud_pkg.
module fud_in_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [fud_pkg::BYTE_W-1:0] in_byte,
	input  logic                      in_last,
	input  logic                      advance,
	output logic                      s1_valid,
	output logic [fud_pkg::BYTE_W-1:0] s1_byte,
	output logic                      s1_last
);
	import fud_pkg::*;

	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic last_s1;

	// take a new word when empty or when the held word leaves this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_byte  = byte_s1;
	assign s1_last  = last_s1;

endmodule

// ===== rtl/fud_decode.sv =====
// Decode step of the form-urlencoded decoder: escape, plus and '=' handling with pair state.
// Depends on fud_pkg.
module fud_decode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic [fud_pkg::BYTE_W-1:0] item_byte,
	input  logic                      item_last,
	input  logic                      advance,
	output logic                      has_result,
	output fud_pkg::dec_res_t         res
);
	import fud_pkg::*;

	esc_phase_t phase_q, phase_d;
	logic [3:0] hi_nib_q, hi_nib_d;
	logic       value_seen_q, value_seen_d;

	logic [7:0] c;
	logic [7:0] digit;
	logic [7:0] dec;
	logic       have_byte;

	always_comb begin
		c            = (item_byte == CH_PLUS) ? CH_SPACE : item_byte;
		digit        = hex_digit(c);
		dec          = c;
		have_byte    = 1'b0;
		phase_d      = phase_q;
		hi_nib_d     = hi_nib_q;
		value_seen_d = value_seen_q;
		res          = '0;

		if (item_byte == CH_AMP) begin
			res.pair_done  = 1'b1;
			res.bad_escape = (phase_q == ESC_HIGH) || (phase_q == ESC_LOW);
		end else begin
			unique case (phase_q)
				ESC_HIGH: begin
					hi_nib_d = digit[3:0];
					phase_d  = ESC_LOW;
				end
				ESC_LOW: begin
					dec       = {hi_nib_q, 4'b0000} + digit;
					have_byte = 1'b1;
					phase_d   = ESC_NONE;
				end
				default: begin
					if (c == CH_PERCENT) begin
						phase_d = ESC_HIGH;
					end else begin
						have_byte = 1'b1;
						phase_d   = ESC_NONE;
					end
				end
			endcase
			if (have_byte) begin
				if (dec == CH_EQUAL && !value_seen_q) begin
					res.name_done = 1'b1;
					value_seen_d  = 1'b1;
				end else begin
					res.out_byte      = dec;
					res.byte_present  = 1'b1;
					res.in_value_part = value_seen_q;
				end
			end
			if (item_last) begin
				res.pair_done  = 1'b1;
				res.bad_escape = (phase_d == ESC_HIGH) || (phase_d == ESC_LOW);
			end
		end

		// a closed pair starts the next one clean
		if (res.pair_done) begin
			phase_d      = ESC_NONE;
			hi_nib_d     = '0;
			value_seen_d = 1'b0;
		end

		has_result = item_valid && (res.byte_present || res.name_done || res.pair_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= ESC_NONE;
			hi_nib_q     <= '0;
			value_seen_q <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			hi_nib_q     <= hi_nib_d;
			value_seen_q <= value_seen_d;
		end
	end

endmodule

// ===== rtl/fud_out_stage.sv =====
// Output register of the form-urlencoded decoder: holds one result word until taken.
// Depends on fud_pkg.
module fud_out_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  fud_pkg::dec_res_t         res,
	output logic                      out_free,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [fud_pkg::BYTE_W-1:0] out_data,
	output logic                      out_last,
	output logic [fud_pkg::USER_W-1:0] out_user
);
	import fud_pkg::*;

	logic     valid_q;
	dec_res_t res_q;

	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = res_q.out_byte;
	assign out_last  = res_q.pair_done;
	assign out_user  = {res_q.bad_escape, res_q.name_done, res_q.in_value_part,
		res_q.byte_present};

endmodule

// ===== rtl/fud_checker.sv =====
// Port-level checks of the form-urlencoded decoder, bound to the top level.
// Depends on fud_pkg and form_urlencoded_decoder_macros.svh.
`include "form_urlencoded_decoder_macros.svh"

module fud_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic [fud_pkg::BYTE_W-1:0] s_axis_tdata,
	input logic                       s_axis_tlast,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [fud_pkg::BYTE_W-1:0] m_axis_tdata,
	input logic                       m_axis_tlast,
	input logic [fud_pkg::USER_W-1:0] m_axis_tuser
);
	import fud_pkg::*;

	`FUD_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_axis_tvalid, "output valid during reset")

	`FUD_ASSERT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled word changed")

	`FUD_ASSERT(a_byte_or_name, clk, arst_n, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[2]) && (m_axis_tuser[0] || m_axis_tuser[2] || m_axis_tlast), "result word kind inconsistent")

	`FUD_ASSERT(a_bad_closes, clk, arst_n, m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tlast, "bad escape without pair end")

	`FUD_ASSERT(a_empty_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1], "no byte but data or part set")

endmodule

bind form_urlencoded_decoder fud_checker u_fud_checker (.*);
